/* design/lphs_pkg.sv */
// ----------------------------------------------------------------------------
// lphs_pkg
// Shared widths, codes, command/status bundles and the key mixing hash
// of the linear-probe hash set.
// ----------------------------------------------------------------------------
package lphs_pkg;

   localparam int ADDR_BITS = 12;
   localparam int KEY_BITS  = 32;
   localparam int DEPTH     = 1 << ADDR_BITS;
   localparam int TB_BITS   = 4;

   localparam logic [TB_BITS-1:0] TB_RESET = TB_BITS'(12);

   localparam int MIX_SHIFT_A = 20;
   localparam int MIX_SHIFT_B = 12;
   localparam int MIX_SHIFT_C = 7;
   localparam int MIX_SHIFT_D = 4;

   typedef enum logic [1:0] {
      STAT_OK   = 2'd0,
      STAT_MISS = 2'd1,
      STAT_FULL = 2'd2,
      STAT_ZERO = 2'd3
   } status_type;

   // controller -> datapath
   typedef struct packed {
      logic load;     // item taken: latch it, read home slot
      logic advance;  // step to next slot and read it
      logic finish;   // latch result, commit insert
      logic clear;    // write one zero of the clearing pass
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic done;      // probe sequence has an answer
      logic clr_last;  // clearing pass at last entry
   } dp_stat_type;

   function automatic logic [KEY_BITS-1:0] mix_key(input logic [KEY_BITS-1:0] k);
      logic [KEY_BITS-1:0] t;
      t = k ^ (k >> MIX_SHIFT_A) ^ (k >> MIX_SHIFT_B);
      return t ^ (t >> MIX_SHIFT_C) ^ (t >> MIX_SHIFT_D);
   endfunction

   // slot mask for a table size, clamped to 1 .. ADDR_BITS
   function automatic logic [ADDR_BITS-1:0] live_mask(input logic [TB_BITS-1:0] tb);
      int lb;
      logic [ADDR_BITS-1:0] m;
      lb = int'(tb);
      if (lb < 1) begin
         lb = 1;
      end
      if (lb > ADDR_BITS) begin
         lb = ADDR_BITS;
      end
      for (int i = 0; i < ADDR_BITS; i++) begin
         m[i] = (i < lb);
      end
      return m;
   endfunction

endpackage

/* design/lphs_req_if.sv */
// ----------------------------------------------------------------------------
// lphs_req_if
// Request channel: operation and key with valid/ready handshake.
// ----------------------------------------------------------------------------
interface lphs_req_if;
   import lphs_pkg::*;

   logic                valid;
   logic                ready;
   logic                operation;
   logic [KEY_BITS-1:0] key;

   modport source (output valid, output operation, output key, input ready);
   modport sink   (input valid, input operation, input key, output ready);
endinterface

/* design/lphs_rsp_if.sv */
// ----------------------------------------------------------------------------
// lphs_rsp_if
// Response channel: status and slot with valid/ready handshake.
// ----------------------------------------------------------------------------
interface lphs_rsp_if;
   import lphs_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [1:0]           status;
   logic [ADDR_BITS-1:0] slot;

   modport source (output valid, output status, output slot, input ready);
   modport sink   (input valid, input status, input slot, output ready);
endinterface

/* design/lphs_ram.sv */
// ----------------------------------------------------------------------------
// lphs_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module lphs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/lphs_ctrl.sv */
// ----------------------------------------------------------------------------
// lphs_ctrl
// Sequencer: clearing pass, item intake, probe loop and response handoff.
// ----------------------------------------------------------------------------
module lphs_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  lphs_pkg::dp_stat_type st,
   output lphs_pkg::ctrl_cmd_type cmd
);
   import lphs_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_PROBE = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (st.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (st.done) begin
               if (out_free) begin
                  cmd.finish = 1'b1;
                  state_in   = ST_IDLE;
               end
            end else begin
               cmd.advance = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef ASSERT_OFF
   a_load_enters_probe: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == ST_PROBE)
      else $error("accepted item did not start probing");

   a_finish_shows_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff)
      else $error("finished item not presented");

   a_probe_continues: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROBE) && !st.done |=> state_ff == ST_PROBE)
      else $error("probe loop left without an answer");

   a_no_load_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !cmd.load && !cmd.finish)
      else $error("item activity during clearing pass");
`endif

endmodule

/* design/lphs_dp.sv */
// ----------------------------------------------------------------------------
// lphs_dp
// Datapath: size register, hash, probe position and count, slot store,
// result decision and response payload.
// ----------------------------------------------------------------------------
module lphs_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [lphs_pkg::TB_BITS-1:0]      csr_wr_data,
   input  logic                              req_operation,
   input  logic [lphs_pkg::KEY_BITS-1:0]     req_key,
   output logic [1:0]                        rsp_status,
   output logic [lphs_pkg::ADDR_BITS-1:0]    rsp_slot,
   input  lphs_pkg::ctrl_cmd_type            cmd,
   output lphs_pkg::dp_stat_type             st
);
   import lphs_pkg::*;

   logic [TB_BITS-1:0]   table_bits_ff;
   logic [ADDR_BITS-1:0] clr_ff;
   logic [KEY_BITS-1:0]  key_ff;
   logic                 lookup_ff;
   logic                 zero_ff;
   logic [ADDR_BITS-1:0] pos_ff;
   logic [ADDR_BITS-1:0] cnt_ff;
   status_type           rsp_status_ff;
   logic [ADDR_BITS-1:0] rsp_slot_ff;

   logic [ADDR_BITS-1:0] mask;
   logic [KEY_BITS-1:0]  hash;
   logic [ADDR_BITS-1:0] home;
   logic [ADDR_BITS-1:0] pos_next;
   logic [KEY_BITS-1:0]  rd_data;
   logic                 empty, equal, last;
   logic                 ins_write;
   status_type           res_status;
   logic [ADDR_BITS-1:0] res_slot;
   logic                 wr_en, rd_en;
   logic [ADDR_BITS-1:0] wr_addr, rd_addr;
   logic [KEY_BITS-1:0]  wr_data;

   assign mask     = live_mask(table_bits_ff);
   assign hash     = mix_key(req_key);
   assign home     = ADDR_BITS'(hash) & mask;
   assign pos_next = (pos_ff + ADDR_BITS'(1)) & mask;

   assign empty = (rd_data == '0);
   assign equal = (rd_data == key_ff);
   assign last  = (cnt_ff == mask);

   // decide the answer for the slot just read
   always_comb begin
      res_status  = STAT_FULL;
      res_slot    = '0;
      st.done     = last;
      st.clr_last = (clr_ff == '1);
      if (zero_ff) begin
         res_status = STAT_ZERO;
         st.done    = 1'b1;
      end else if (empty && !lookup_ff) begin
         res_status = STAT_OK;
         res_slot   = pos_ff;
         st.done    = 1'b1;
      end else if (empty) begin
         res_status = STAT_MISS;
         st.done    = 1'b1;
      end else if (lookup_ff && equal) begin
         res_status = STAT_OK;
         res_slot   = pos_ff;
         st.done    = 1'b1;
      end
   end

   assign ins_write   = !zero_ff && !lookup_ff && empty;

   assign wr_en   = cmd.clear || (cmd.finish && ins_write);
   assign wr_addr = cmd.clear ? clr_ff : pos_ff;
   assign wr_data = cmd.clear ? '0 : key_ff;
   assign rd_en   = cmd.load || cmd.advance;
   assign rd_addr = cmd.load ? home : pos_next;

   lphs_ram #(
      .WIDTH (KEY_BITS),
      .DEPTH (DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         table_bits_ff <= TB_RESET;
         clr_ff        <= '0;
      end else begin
         if (csr_wr_en) begin
            table_bits_ff <= csr_wr_data;
         end
         if (cmd.clear) begin
            clr_ff <= clr_ff + ADDR_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff    <= req_key;
         lookup_ff <= req_operation;
         zero_ff   <= (req_key == '0);
         pos_ff    <= home;
         cnt_ff    <= '0;
      end else if (cmd.advance) begin
         pos_ff <= pos_next;
         cnt_ff <= cnt_ff + ADDR_BITS'(1);
      end
      if (cmd.finish) begin
         rsp_status_ff <= res_status;
         rsp_slot_ff   <= res_slot;
      end
   end

   assign rsp_status = rsp_status_ff;
   assign rsp_slot   = rsp_slot_ff;

endmodule

/* design/linear_probe_hash_set_core.sv */
// The probe loop reads the slot store once per cycle, one slot after the next, until it has an answer.
// A new item is taken only after the previous one has left the probe loop; an answer
// that is ready waits in the probe loop while the response register is still full.
// The response register lets the next item in while a response still waits.
// Reset: synchronous, active high; table_bits returns to 12 and a clearing pass over all
// 4096 entries zeroes the slot store, during which no item is taken.
// ----------------------------------------------------------------------------
// linear_probe_hash_set_core
// Open-addressed hash set of nonzero keys with linear probing: insert keeps
// duplicates, lookup stops at an equal key or an empty slot, a full sweep
// reports the table full.
// ----------------------------------------------------------------------------
module linear_probe_hash_set_core (
   input  logic                         clock,
   input  logic                         reset,
   lphs_req_if.sink                     req_ch,
   lphs_rsp_if.source                   rsp_ch,
   input  logic                         csr_wr_en,
   input  logic [lphs_pkg::TB_BITS-1:0] csr_wr_data
);
   import lphs_pkg::*;

   ctrl_cmd_type cmd;
   dp_stat_type  st;
   logic         req_ready;
   logic         rsp_valid;

   // Sequencer: clears the store after reset, takes one item at a time,
   // steps the probe loop and hands the answer to the response register.
   lphs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ch.ready),
      .st        (st),
      .cmd       (cmd)
   );

   // Datapath: hashes the key, walks the slots, holds the size register
   // and the response payload.
   lphs_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_operation (req_ch.operation),
      .req_key       (req_ch.key),
      .rsp_status    (rsp_ch.status),
      .rsp_slot      (rsp_ch.slot),
      .cmd           (cmd),
      .st            (st)
   );

   // Drive the handshake lines of both channels.
   assign req_ch.ready = req_ready;
   assign rsp_ch.valid = rsp_valid;

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the linear-probe hash set: a shadow slot store
// predicts every answer, a driver and a monitor work the two channels under
// random idling, and the table size is swept between phases.
// ----------------------------------------------------------------------------
module tb_top;
   import lphs_pkg::*;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;
   localparam int   SETTLE_CYCLES = 6;

   typedef struct {
      logic                operation;
      logic [KEY_BITS-1:0] key;
   } set_item_type;

   typedef struct {
      logic                 operation;
      logic [KEY_BITS-1:0]  key;
      status_type           status;
      logic [ADDR_BITS-1:0] slot;
   } set_answer_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [TB_BITS-1:0] csr_wr_data;

   lphs_req_if req_bus ();
   lphs_rsp_if rsp_bus ();

   linear_probe_hash_set_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_bus),
      .rsp_ch      (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // shadow of the block: slot store and table size register
   logic [KEY_BITS-1:0] shadow_slots [DEPTH];
   logic [TB_BITS-1:0]  shadow_table_bits;

   set_item_type   item_backlog [$];
   set_answer_type awaited_answers [$];
   logic [KEY_BITS-1:0] inserted_keys [$];

   bit req_fire;
   int send_idle_pct;
   int recv_idle_pct;
   int mismatch_count;
   int insert_count;
   int lookup_count;
   int setting_count;
   int status_seen [4];

   // 12 ns clock
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // supplemental hash: fold the high bits down, then spread them again
   function automatic logic [KEY_BITS-1:0] home_hash(input logic [KEY_BITS-1:0] k);
      logic [KEY_BITS-1:0] h;
      h = k ^ (k >> 20) ^ (k >> 12);
      return h ^ (h >> 7) ^ (h >> 4);
   endfunction

   // Predict one operation against the shadow store and commit any insert.
   task automatic probe_table(input logic op, input logic [KEY_BITS-1:0] key,
                              output status_type st, output logic [ADDR_BITS-1:0] at);
      int                   size_bits;
      int                   n;
      logic [ADDR_BITS-1:0] mask;
      logic [ADDR_BITS-1:0] pos;
      logic [KEY_BITS-1:0]  hashed;
      logic [KEY_BITS-1:0]  cur;
      bit                   stop;
      st = STAT_FULL;
      at = '0;
      stop = 1'b0;
      // clamp the register to 1 .. ADDR_BITS
      size_bits = int'(shadow_table_bits);
      if (size_bits < 1) begin
         size_bits = 1;
      end
      if (size_bits > ADDR_BITS) begin
         size_bits = ADDR_BITS;
      end
      mask = ADDR_BITS'((1 << size_bits) - 1);
      if (key == '0) begin
         st = STAT_ZERO;
      end else begin
         hashed = home_hash(key);
         pos = hashed[ADDR_BITS-1:0] & mask;
         // one sweep at most; a full sweep leaves the status at table full
         for (n = 0; n <= int'(mask) && !stop; n++) begin
            cur = shadow_slots[pos];
            if (op == OP_INSERT) begin
               if (cur == '0) begin
                  shadow_slots[pos] = key;
                  st = STAT_OK;
                  at = pos;
                  stop = 1'b1;
               end
            end else if (cur == '0) begin
               st = STAT_MISS;
               stop = 1'b1;
            end else if (cur == key) begin
               st = STAT_OK;
               at = pos;
               stop = 1'b1;
            end
            pos = (pos + 1'b1) & mask;
         end
      end
   endtask

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("[%0t] MISMATCH: %s", $realtime, what);
   endtask

   // Monitor: check answers first, then predict for an item taken at this edge.
   always @(posedge clock) begin
      set_answer_type exp_ans;
      set_answer_type new_ans;
      if (reset) begin
         req_fire = 1'b0;
      end else begin
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (awaited_answers.size() == 0) begin
               report_mismatch($sformatf("answer status=%0d slot=%0d with nothing awaited",
                                         rsp_bus.status, rsp_bus.slot));
            end else begin
               exp_ans = awaited_answers.pop_front();
               status_seen[exp_ans.status]++;
               if (rsp_bus.status !== exp_ans.status) begin
                  report_mismatch($sformatf("op=%0d key=%h status %0d, want %0d",
                                            exp_ans.operation, exp_ans.key,
                                            rsp_bus.status, exp_ans.status));
               end
               if (rsp_bus.slot !== exp_ans.slot) begin
                  report_mismatch($sformatf("op=%0d key=%h slot %0d, want %0d",
                                            exp_ans.operation, exp_ans.key,
                                            rsp_bus.slot, exp_ans.slot));
               end
            end
         end
         req_fire = (req_bus.valid === 1'b1) && (req_bus.ready === 1'b1);
         if (req_fire) begin
            new_ans.operation = req_bus.operation;
            new_ans.key = req_bus.key;
            probe_table(req_bus.operation, req_bus.key, new_ans.status, new_ans.slot);
            awaited_answers.push_back(new_ans);
            if (req_bus.operation == OP_INSERT) begin
               insert_count++;
            end else begin
               lookup_count++;
            end
         end
      end
   end

   // Driver: hold an offered item until it is taken, otherwise offer the next
   // one unless the sender idles this cycle.
   always @(negedge clock) begin
      set_item_type nxt;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_fire) begin
         if (item_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt = item_backlog.pop_front();
            req_bus.valid <= 1'b1;
            req_bus.operation <= nxt.operation;
            req_bus.key <= nxt.key;
         end else begin
            // drop valid and scramble the payload while idle
            req_bus.valid <= 1'b0;
            req_bus.operation <= 1'($urandom_range(1));
            req_bus.key <= $urandom;
         end
      end
   end

   // Receiver: stall at random according to the current idling mode.
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic queue_item(input logic op, input logic [KEY_BITS-1:0] key);
      set_item_type it;
      it.operation = op;
      it.key = key;
      item_backlog.push_back(it);
      if (op == OP_INSERT && key != '0) begin
         inserted_keys.push_back(key);
      end
   endtask

   // Write the table size; only ever called with the block idle.
   task automatic write_table_bits(input logic [TB_BITS-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      csr_wr_data <= TB_BITS'($urandom);
      shadow_table_bits = value;
      setting_count++;
   endtask

   // Wait until every item is taken and answered, then let the pipe drain.
   task automatic settle();
      while (item_backlog.size() != 0 || req_bus.valid || awaited_answers.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // idling mode 0: sender 38 %, receiver 66 %; 1: swapped; 2: no idling
   task automatic set_idling(input int mode);
      case (mode)
         0: begin
            send_idle_pct = 38;
            recv_idle_pct = 66;
         end
         1: begin
            send_idle_pct = 66;
            recv_idle_pct = 38;
         end
         default: begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
      endcase
   endtask

   // Random key: mostly keys seen before or small values so that lookups hit
   // and clusters build up, with the odd zero key and wide random keys.
   function automatic logic [KEY_BITS-1:0] pick_key();
      int r;
      r = $urandom_range(99);
      if (r < 4) begin
         return '0;
      end else if (r < 42 && inserted_keys.size() != 0) begin
         return inserted_keys[$urandom_range(inserted_keys.size() - 1)];
      end else if (r < 55) begin
         return KEY_BITS'($urandom_range(64, 1));
      end else if (r < 60) begin
         return ~KEY_BITS'($urandom_range(64, 0));
      end
      return $urandom;
   endfunction

   // Stimulus: directed checks, then random phases over several table sizes.
   initial begin
      int phase_bits [7];
      int phase_items [7];
      int phase_mode [7];
      int p;
      int i;
      int w;
      phase_bits  = '{12, 3, 15, 6, 1, 9, 12};
      phase_items = '{120, 60, 100, 100, 30, 100, 60};
      phase_mode  = '{0, 0, 1, 1, 2, 2, 2};

      // every input known from the start
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_bus.valid = 1'b0;
      req_bus.operation = OP_INSERT;
      req_bus.key = '0;
      rsp_bus.ready = 1'b0;
      mismatch_count = 0;
      insert_count = 0;
      lookup_count = 0;
      setting_count = 0;
      status_seen = '{0, 0, 0, 0};
      foreach (shadow_slots[k]) begin
         shadow_slots[k] = '0;
      end
      shadow_table_bits = TB_RESET;
      set_idling(0);

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // let the clearing pass finish before touching the register
      for (w = 0; w < 5000 && req_bus.ready !== 1'b1; w++) begin
         @(posedge clock);
      end

      // directed: largest table, extremes of the key, duplicates, a miss
      write_table_bits(TB_BITS'(12));
      queue_item(OP_INSERT, 32'h0000_0000);
      queue_item(OP_LOOKUP, 32'h0000_0000);
      queue_item(OP_INSERT, 32'hFFFF_FFFF);
      queue_item(OP_LOOKUP, 32'hFFFF_FFFF);
      queue_item(OP_INSERT, 32'h0000_0001);
      queue_item(OP_INSERT, 32'h0000_0001);
      queue_item(OP_LOOKUP, 32'h0000_0001);
      queue_item(OP_LOOKUP, 32'h8000_0000);
      queue_item(OP_INSERT, 32'h8000_0000);
      queue_item(OP_LOOKUP, 32'h8000_0000);
      queue_item(OP_INSERT, 32'h1234_5678);
      settle();

      // size below range clamps to two slots: fill them, then sweep a full table
      write_table_bits(TB_BITS'(0));
      queue_item(OP_INSERT, 32'h0000_0002);
      queue_item(OP_INSERT, 32'h0000_0003);
      queue_item(OP_INSERT, 32'h0000_0004);
      queue_item(OP_LOOKUP, 32'h0000_0005);
      queue_item(OP_LOOKUP, 32'h0000_0002);
      queue_item(OP_LOOKUP, 32'h1234_5678);
      queue_item(OP_INSERT, 32'h0000_0000);
      settle();

      // size above range clamps to the full store
      write_table_bits(TB_BITS'(15));
      queue_item(OP_LOOKUP, 32'hFFFF_FFFF);
      queue_item(OP_LOOKUP, 32'h0000_0004);
      queue_item(OP_LOOKUP, 32'h0000_0002);
      queue_item(OP_INSERT, 32'h7FFF_FFFF);
      queue_item(OP_LOOKUP, 32'h7FFF_FFFF);
      settle();

      // random phases; the store carries over, so shrunk tables see old keys
      for (p = 0; p < 7; p++) begin
         set_idling(phase_mode[p]);
         write_table_bits(TB_BITS'(phase_bits[p]));
         for (i = 0; i < phase_items[p]; i++) begin
            queue_item(($urandom_range(99) < 50) ? OP_INSERT : OP_LOOKUP, pick_key());
         end
         settle();
      end

      if (awaited_answers.size() != 0) begin
         report_mismatch($sformatf("%0d answers never arrived", awaited_answers.size()));
      end

      $display("Covered %0d items (%0d inserts, %0d lookups) over %0d table size settings",
               insert_count + lookup_count, insert_count, lookup_count, setting_count);
      $display("Answers seen: %0d stored/found, %0d not found, %0d table full, %0d zero key",
               status_seen[STAT_OK], status_seen[STAT_MISS], status_seen[STAT_FULL],
               status_seen[STAT_ZERO]);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run, even with every item sweeping
   // the whole store, including the clearing pass.
   initial begin
      #200_000_000;
      $display("Run timed out with %0d answers awaited", awaited_answers.size());
      $display("Mismatches found");
      $finish;
   end

endmodule
